/* design/ray_rectangle_intersect_defines.svh */
// Assertion shorthands shared by the design files.
`ifndef RAY_RECTANGLE_INTERSECT_DEFINES_SVH
`define RAY_RECTANGLE_INTERSECT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define RRI_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define RRI_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    `RRI_ASSERT(lbl, ck, rn, !(cond), msg)

`endif

/* design/rri_pkg.sv */
package rri_pkg;

    localparam int COORD_WIDTH_DEF   = 20;
    localparam int FRACTION_BITS_DEF = 8;

    // distance is unsigned Q16.16
    localparam int DIST_W    = 32;
    localparam int DIST_FRAC = 16;
    localparam int MIN_W     = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CORNER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_A  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_B  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHADOWS = 3'd5;

    localparam logic [MIN_W-1:0] MIN_DIST_RST = 16'd66;

    typedef struct packed {
        logic vld;
        logic shadow;
        logic miss;
    } rri_tag_t;

endpackage

/* design/rri_front.sv */
module rri_front
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic                              func,
    input  logic signed [COORD_WIDTH-1:0]     origin_x,
    input  logic signed [COORD_WIDTH-1:0]     origin_y,
    input  logic signed [COORD_WIDTH-1:0]     origin_z,
    input  logic signed [COORD_WIDTH-1:0]     dir_x,
    input  logic signed [COORD_WIDTH-1:0]     dir_y,
    input  logic signed [COORD_WIDTH-1:0]     dir_z,
    input  logic [3*COORD_WIDTH-1:0]          corner,
    input  logic [3*COORD_WIDTH-1:0]          normal,
    input  logic                              shadows_en,
    output rri_tag_t                          push_tag,
    output logic [3*COORD_WIDTH-1:0]          push_org,
    output logic [3*COORD_WIDTH-1:0]          push_dir,
    output logic [2*COORD_WIDTH+2:0]          push_num,
    output logic [2*COORD_WIDTH+1:0]          push_den
);

    localparam int CW     = COORD_WIDTH;
    localparam int DIFF_W = CW + 1;
    localparam int NP_W   = 2 * CW + 1;
    localparam int DP_W   = 2 * CW;
    localparam int NUM_W  = 2 * CW + 3;
    localparam int DEN_W  = 2 * CW + 2;

    logic signed [CW-1:0]     org_in [3];
    logic signed [CW-1:0]     dir_in [3];
    logic signed [CW-1:0]     crn    [3];
    logic signed [CW-1:0]     nrm    [3];
    logic signed [DIFF_W-1:0] diff   [3];
    logic signed [NP_W-1:0]   np_next [3];
    logic signed [DP_W-1:0]   dp_next [3];
    logic signed [NP_W-1:0]   np_reg  [3];
    logic signed [DP_W-1:0]   dp_reg  [3];
    logic                     vld_reg;
    logic                     shadow_reg;
    logic                     skip_reg;
    logic [3*CW-1:0]          org_reg;
    logic [3*CW-1:0]          dir_reg;
    logic signed [NUM_W-1:0]  num_sum;
    logic signed [DEN_W-1:0]  den_sum;
    logic signed [NUM_W-1:0]  num_fix;
    logic signed [DEN_W-1:0]  den_fix;

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;
    assign crn[0]    = corner[3*CW-1:2*CW];
    assign crn[1]    = corner[2*CW-1:CW];
    assign crn[2]    = corner[CW-1:0];
    assign nrm[0]    = normal[3*CW-1:2*CW];
    assign nrm[1]    = normal[2*CW-1:CW];
    assign nrm[2]    = normal[CW-1:0];

    // per-axis products of the two plane dot products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]    = DIFF_W'(crn[i]) - DIFF_W'(org_in[i]);
            np_next[i] = NP_W'(diff[i]) * NP_W'(nrm[i]);
            dp_next[i] = DP_W'(dir_in[i]) * DP_W'(nrm[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            shadow_reg <= func;
            skip_reg   <= func && !shadows_en;
            org_reg    <= {origin_x, origin_y, origin_z};
            dir_reg    <= {dir_x, dir_y, dir_z};
            for (int i = 0; i < 3; i++)
            begin
                np_reg[i] <= np_next[i];
                dp_reg[i] <= dp_next[i];
            end
        end
    end

    // sum, flip signs so the denominator is positive, classify early misses
    always_comb
    begin
        num_sum = NUM_W'(np_reg[0]) + NUM_W'(np_reg[1]) + NUM_W'(np_reg[2]);
        den_sum = DEN_W'(dp_reg[0]) + DEN_W'(dp_reg[1]) + DEN_W'(dp_reg[2]);
        num_fix = den_sum[DEN_W-1] ? -num_sum : num_sum;
        den_fix = den_sum[DEN_W-1] ? -den_sum : den_sum;
    end

    assign push_tag.vld    = vld_reg;
    assign push_tag.shadow = shadow_reg;
    assign push_tag.miss   = skip_reg || (den_sum == '0) || num_fix[NUM_W-1]
                             || (num_fix == '0);
    assign push_org        = org_reg;
    assign push_dir        = dir_reg;
    assign push_num        = num_fix;
    assign push_den        = den_fix;

endmodule

/* design/rri_queue.sv */
`include "ray_rectangle_intersect_defines.svh"

module rri_queue
    import rri_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    output logic                     pop_vld,
    output logic [WIDTH-1:0]         pop_data,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    // the back end never stalls: drain the head every cycle it holds a beat
    assign pop      = (count_reg != '0);
    assign pop_vld  = pop;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RRI_ASSERT(a_q_no_overflow, clk, rst_n, push |-> (int'(count_reg) < DEPTH || pop), "queue overflow")

endmodule

/* design/rri_div.sv */
module rri_div
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int SIDE_W      = 6 * COORD_WIDTH_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rri_tag_t                   in_tag,
    input  logic [2*COORD_WIDTH+2:0]   in_num,
    input  logic [2*COORD_WIDTH+1:0]   in_den,
    input  logic [SIDE_W-1:0]          in_side,
    output rri_tag_t                   out_tag,
    output logic [DIST_W-1:0]          out_t,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int CW    = COORD_WIDTH;
    localparam int DEN_W = 2 * CW + 2;
    localparam int REM_W = DEN_W + 1;
    localparam int CMP_W = DEN_W + DIST_FRAC;
    localparam int STG   = DIST_W;

    rri_tag_t          tag_reg  [STG+1];
    logic [DEN_W-1:0]  rem_reg  [STG+1];
    logic [DIST_W-1:0] quo_reg  [STG+1];
    logic [DIST_W-1:0] bit_reg  [STG+1];
    logic [DEN_W-1:0]  den_reg  [STG+1];
    logic              sat_reg  [STG+1];
    logic [SIDE_W-1:0] side_reg [STG+1];

    // seed: the top of num<<16 is the first partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DEN_W'(in_num >> DIST_FRAC);
        bit_reg[0]  <= {in_num[DIST_FRAC-1:0], {(DIST_W-DIST_FRAC){1'b0}}};
        quo_reg[0]  <= '0;
        den_reg[0]  <= in_den;
        sat_reg[0]  <= CMP_W'(in_num) >= (CMP_W'(in_den) << DIST_FRAC);
        side_reg[0] <= in_side;
    end

    // one quotient bit per stage, restoring
    for (genvar s = 1; s <= STG; s++)
    begin : g_stage
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            trial = {rem_reg[s-1], bit_reg[s-1][DIST_W-1]};
            ge    = trial >= REM_W'(den_reg[s-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= ge ? DEN_W'(trial - REM_W'(den_reg[s-1])) : DEN_W'(trial);
            quo_reg[s]  <= {quo_reg[s-1][DIST_W-2:0], ge};
            bit_reg[s]  <= bit_reg[s-1] << 1;
            den_reg[s]  <= den_reg[s-1];
            sat_reg[s]  <= sat_reg[s-1];
            side_reg[s] <= side_reg[s-1];
        end
    end

    assign out_tag  = tag_reg[STG];
    assign out_t    = sat_reg[STG] ? '1 : quo_reg[STG];
    assign out_side = side_reg[STG];

endmodule

/* design/rri_back.sv */
module rri_back
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rri_tag_t                       in_tag,
    input  logic [3*COORD_WIDTH-1:0]       in_org,
    input  logic [3*COORD_WIDTH-1:0]       in_dir,
    input  logic [2*COORD_WIDTH+2:0]       in_num,
    input  logic [2*COORD_WIDTH+1:0]       in_den,
    input  logic [3*COORD_WIDTH-1:0]       corner,
    input  logic [3*COORD_WIDTH-1:0]       edge_a,
    input  logic [3*COORD_WIDTH-1:0]       edge_b,
    input  logic [MIN_W-1:0]               min_dist,
    output logic                           done,
    output logic                           hit,
    output logic [DIST_W-1:0]              distance,
    output logic signed [COORD_WIDTH-1:0]  point_x,
    output logic signed [COORD_WIDTH-1:0]  point_y,
    output logic signed [COORD_WIDTH-1:0]  point_z
);

    localparam int CW     = COORD_WIDTH;
    localparam int SIDE_W = 6 * CW;
    localparam int TD_W   = DIST_W + 1 + CW;
    localparam int PW     = CW + 18;
    localparam int RW     = PW + 1;
    localparam int JP_W   = RW + CW;
    localparam int JS_W   = JP_W + 2;
    localparam int AA_W   = 2 * CW;

    rri_tag_t             dv_tag;
    logic [DIST_W-1:0]    dv_t;
    logic [SIDE_W-1:0]    dv_side;

    logic signed [CW-1:0] crn [3];
    logic signed [CW-1:0] ea  [3];
    logic signed [CW-1:0] eb  [3];

    rri_tag_t             m_tag_reg;
    logic [DIST_W-1:0]    m_t_reg;
    logic signed [TD_W-1:0] m_td_reg  [3];
    logic signed [CW-1:0]   m_org_reg [3];
    logic signed [TD_W-1:0] td_next   [3];
    logic                 miss_next;

    rri_tag_t             p_tag_reg;
    logic [DIST_W-1:0]    p_t_reg;
    logic signed [PW-1:0] p_pt_reg  [3];
    logic signed [RW-1:0] p_rel_reg [3];
    logic signed [PW-1:0] pt_next   [3];
    logic signed [RW-1:0] rel_next  [3];

    rri_tag_t              j_tag_reg;
    logic [DIST_W-1:0]     j_t_reg;
    logic signed [PW-1:0]  j_pt_reg [3];
    logic signed [JP_W-1:0] j_pa_reg [3];
    logic signed [JP_W-1:0] j_pb_reg [3];
    logic signed [AA_W-1:0] j_aa_reg [3];
    logic signed [AA_W-1:0] j_bb_reg [3];

    logic signed [JS_W-1:0] sum_a;
    logic signed [JS_W-1:0] sum_b;
    logic signed [JS_W-1:0] len_a;
    logic signed [JS_W-1:0] len_b;
    logic                   hit_next;
    logic [PW-CW:0]         hi_bits;
    logic signed [CW-1:0]   sat_pt [3];

    logic                   done_reg;
    logic                   hit_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic signed [CW-1:0]   pt_reg [3];

    rri_div #(
        .COORD_WIDTH (CW),
        .SIDE_W      (SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (in_tag),
        .in_num   (in_num),
        .in_den   (in_den),
        .in_side  ({in_org, in_dir}),
        .out_tag  (dv_tag),
        .out_t    (dv_t),
        .out_side (dv_side)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_cfg
        assign crn[i] = corner[(3-i)*CW-1 -: CW];
        assign ea[i]  = edge_a[(3-i)*CW-1 -: CW];
        assign eb[i]  = edge_b[(3-i)*CW-1 -: CW];
    end

    // t * D
    always_comb
    begin
        miss_next = dv_tag.miss || (dv_t <= DIST_W'(min_dist));
        for (int i = 0; i < 3; i++)
        begin
            td_next[i] = TD_W'($signed({1'b0, dv_t}))
                         * TD_W'($signed(dv_side[(3-i)*CW-1 -: CW]));
        end
    end

    // P = O + floor(t*D), rel = P - C
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt_next[i]  = PW'(m_org_reg[i]) + PW'(m_td_reg[i] >>> DIST_FRAC);
            rel_next[i] = RW'(pt_next[i]) - RW'(crn[i]);
        end
    end

    // projection sums and clamp of the reported point
    always_comb
    begin
        sum_a = JS_W'(j_pa_reg[0]) + JS_W'(j_pa_reg[1]) + JS_W'(j_pa_reg[2]);
        sum_b = JS_W'(j_pb_reg[0]) + JS_W'(j_pb_reg[1]) + JS_W'(j_pb_reg[2]);
        len_a = JS_W'(j_aa_reg[0]) + JS_W'(j_aa_reg[1]) + JS_W'(j_aa_reg[2]);
        len_b = JS_W'(j_bb_reg[0]) + JS_W'(j_bb_reg[1]) + JS_W'(j_bb_reg[2]);
        hit_next = j_tag_reg.vld && !j_tag_reg.miss
                   && !sum_a[JS_W-1] && (sum_a <= len_a)
                   && !sum_b[JS_W-1] && (sum_b <= len_b);
        hi_bits = '0;
        for (int i = 0; i < 3; i++)
        begin
            hi_bits = j_pt_reg[i][PW-1:CW-1];
            priority if (hi_bits == '0 || hi_bits == '1)
            begin
                sat_pt[i] = j_pt_reg[i][CW-1:0];
            end
            else if (j_pt_reg[i][PW-1])
            begin
                sat_pt[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                sat_pt[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tag_reg <= '0;
            p_tag_reg <= '0;
            j_tag_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            m_tag_reg <= '{vld: dv_tag.vld, shadow: dv_tag.shadow, miss: miss_next};
            p_tag_reg <= m_tag_reg;
            j_tag_reg <= p_tag_reg;
            done_reg  <= j_tag_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m_t_reg  <= dv_t;
        p_t_reg  <= m_t_reg;
        j_t_reg  <= p_t_reg;
        hit_reg  <= hit_next;
        dist_reg <= hit_next ? j_t_reg : '0;
        for (int i = 0; i < 3; i++)
        begin
            m_td_reg[i]  <= td_next[i];
            m_org_reg[i] <= dv_side[SIDE_W-1-i*CW -: CW];
            p_pt_reg[i]  <= pt_next[i];
            p_rel_reg[i] <= rel_next[i];
            j_pt_reg[i]  <= p_pt_reg[i];
            j_pa_reg[i]  <= JP_W'(p_rel_reg[i]) * JP_W'(ea[i]);
            j_pb_reg[i]  <= JP_W'(p_rel_reg[i]) * JP_W'(eb[i]);
            j_aa_reg[i]  <= AA_W'(ea[i]) * AA_W'(ea[i]);
            j_bb_reg[i]  <= AA_W'(eb[i]) * AA_W'(eb[i]);
            pt_reg[i]    <= (hit_next && !j_tag_reg.shadow) ? sat_pt[i] : '0;
        end
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = dist_reg;
    assign point_x  = pt_reg[0];
    assign point_y  = pt_reg[1];
    assign point_z  = pt_reg[2];

endmodule

/* design/ray_rectangle_intersect.sv */
// Ray against rectangle test. Pulse start with a ray while busy is low and
// the ray is taken on that edge; while busy is low, one ray can be taken
// every clock cycle. Exactly one result comes back per ray, in order, as a
// one-cycle done strobe after the ray has passed the front register, the
// queue slot, the divider seed register, the bit-per-stage quotient of t
// and the hit point, projection and output registers. The receiver cannot
// stall: sample hit, distance and point_* in the cycle done is high. A miss
// reports all fields zero; a shadow query reports only hit and distance. Write
// the rectangle registers only while no ray is in flight.
`include "ray_rectangle_intersect_defines.svh"

module ray_rectangle_intersect
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic signed [COORD_WIDTH-1:0]  origin_x,
    input  logic signed [COORD_WIDTH-1:0]  origin_y,
    input  logic signed [COORD_WIDTH-1:0]  origin_z,
    input  logic signed [COORD_WIDTH-1:0]  dir_x,
    input  logic signed [COORD_WIDTH-1:0]  dir_y,
    input  logic signed [COORD_WIDTH-1:0]  dir_z,
    input  logic                           wr_en,
    input  logic [REG_IDX_W-1:0]           wr_index,
    input  logic [3*COORD_WIDTH-1:0]       wr_data,
    output logic                           done,
    output logic                           hit,
    output logic [DIST_W-1:0]              distance,
    output logic signed [COORD_WIDTH-1:0]  point_x,
    output logic signed [COORD_WIDTH-1:0]  point_y,
    output logic signed [COORD_WIDTH-1:0]  point_z
);

    localparam int CW     = COORD_WIDTH;
    localparam int NUM_W  = 2 * CW + 3;
    localparam int DEN_W  = 2 * CW + 2;
    localparam int Q_W    = 2 + 6 * CW + NUM_W + DEN_W;
    // edges from the taking of a ray to the sampling of its done strobe
    localparam int RESULT_LAT = 3 + DIST_W + 4;

    // reset rectangle: corner (-1,0,-1), edges (0,0,2) and (2,0,0), normal +y
    localparam logic [CW-1:0] Q_ONE  = CW'(1 << FRACTION_BITS);
    localparam logic [CW-1:0] Q_TWO  = CW'(2 << FRACTION_BITS);
    localparam logic [CW-1:0] Q_MONE = CW'(0) - Q_ONE;
    localparam logic [CW-1:0] Q_ZERO = '0;

    logic [3*CW-1:0]     corner_reg;
    logic [3*CW-1:0]     edge_a_reg;
    logic [3*CW-1:0]     edge_b_reg;
    logic [3*CW-1:0]     normal_reg;
    logic [MIN_W-1:0]    min_dist_reg;
    logic                shadows_reg;

    logic                take;
    rri_tag_t            push_tag;
    logic [3*CW-1:0]     push_org;
    logic [3*CW-1:0]     push_dir;
    logic [NUM_W-1:0]    push_num;
    logic [DEN_W-1:0]    push_den;

    logic                q_vld;
    logic [Q_W-1:0]      q_data;
    logic [$clog2(QUEUE_DEPTH):0] q_count;
    rri_tag_t            back_tag;

    // Hold the rectangle; writes land on the edge wr_en is high, unknown
    // indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg   <= {Q_MONE, Q_ZERO, Q_MONE};
            edge_a_reg   <= {Q_ZERO, Q_ZERO, Q_TWO};
            edge_b_reg   <= {Q_TWO, Q_ZERO, Q_ZERO};
            normal_reg   <= {Q_ZERO, Q_ONE, Q_ZERO};
            min_dist_reg <= MIN_DIST_RST;
            shadows_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CORNER:  corner_reg   <= wr_data;
                REG_EDGE_A:  edge_a_reg   <= wr_data;
                REG_EDGE_B:  edge_b_reg   <= wr_data;
                REG_NORMAL:  normal_reg   <= wr_data;
                REG_MIN:     min_dist_reg <= wr_data[MIN_W-1:0];
                REG_SHADOWS: shadows_reg  <= wr_data[0];
                default:     ;
            endcase
        end
    end

    // Credit check: hold off new rays only if the queue plus the beat in the
    // front register could overrun it. The back end drains a beat every
    // cycle, so in practice busy stays low.
    assign busy = (int'(q_count) + int'(push_tag.vld)) >= QUEUE_DEPTH;
    assign take = start && !busy;

    // Front end: plane dot products, sign fix-up, early miss classification.
    rri_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .func       (func),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .corner     (corner_reg),
        .normal     (normal_reg),
        .shadows_en (shadows_reg),
        .push_tag   (push_tag),
        .push_org   (push_org),
        .push_dir   (push_dir),
        .push_num   (push_num),
        .push_den   (push_den)
    );

    // Decouple front and back with a short beat queue.
    rri_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_tag.vld),
        .push_data ({push_tag.shadow, push_tag.miss, push_org, push_dir,
                     push_num, push_den}),
        .pop_vld   (q_vld),
        .pop_data  (q_data),
        .count     (q_count)
    );

    assign back_tag = '{vld: q_vld, shadow: q_data[Q_W-1], miss: q_data[Q_W-2]};

    // Back end: divide for t, then hit point, edge projections and output.
    rri_back #(
        .COORD_WIDTH (CW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (back_tag),
        .in_org   (q_data[Q_W-3 -: 3*CW]),
        .in_dir   (q_data[Q_W-3-3*CW -: 3*CW]),
        .in_num   (q_data[NUM_W+DEN_W-1 -: NUM_W]),
        .in_den   (q_data[DEN_W-1:0]),
        .corner   (corner_reg),
        .edge_a   (edge_a_reg),
        .edge_b   (edge_b_reg),
        .min_dist (min_dist_reg),
        .done     (done),
        .hit      (hit),
        .distance (distance),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z)
    );

    `RRI_ASSERT(a_result_latency, clk, rst_n, done |-> $past(take, RESULT_LAT), "result without a ray taken at the fixed latency")
    `RRI_ASSERT(a_hit_beyond_min, clk, rst_n, (done && hit) |-> (distance > DIST_W'(min_dist_reg)), "hit at or below minimum distance")
    `RRI_ASSERT_NEVER(a_miss_fields_zero, clk, rst_n, done && !hit && (distance != '0 || point_x != '0 || point_y != '0 || point_z != '0), "miss with nonzero fields")

endmodule
